### src/sbh_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
// No dependencies; the datapath, controller, top level and testbench use this package.
package sbh_pkg;

	localparam int unsigned WordW   = 32;
	localparam int unsigned BlkBytes = 64;
	localparam logic [7:0]  PadByte = 8'h80;

	typedef logic [WordW-1:0] word_t;

	typedef enum logic [1:0] {
		PUSH_DATA,
		PUSH_PAD,
		PUSH_ZERO,
		PUSH_LEN
	} push_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic      push;
		push_sel_t sel;
		logic [2:0] len_idx;
		logic [2:0] out_idx;
		logic      clear_msg;
	} sbh_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic busy;
		logic pos_last;
		logic pos_at_56;
	} sbh_sts_t;

	localparam word_t Iv [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic word_t ror(input word_t v, input int unsigned s);
		ror = (v >> s) | (v << (WordW - s));
	endfunction

	function automatic word_t big_sig0(input word_t x);
		big_sig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic word_t big_sig1(input word_t x);
		big_sig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	function automatic word_t sml_sig0(input word_t x);
		sml_sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sml_sig1(input word_t x);
		sml_sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

endpackage

### src/sbh_in_if.sv
// Input channel of the hasher: valid/ready plus one byte request.
// Depends on nothing.
interface sbh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

### src/sbh_out_if.sv
// Output channel of the hasher: valid/ready plus one digest word request.
// Depends on nothing.
interface sbh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### src/sbh_datapath.sv
// Datapath: byte shift line, bit counter, message schedule, round unit, chain hash.
// Depends on sbh_pkg.
module sbh_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  sbh_pkg::sbh_cmd_t cmd,
	input  logic [7:0]        data_byte,
	output sbh_pkg::sbh_sts_t sts,
	output logic [31:0]       digest_word
);
	import sbh_pkg::*;

	logic [8*BlkBytes-1:0] buf_q;
	logic [8*BlkBytes-1:0] buf_next;
	logic [5:0]  pos_q;
	logic [63:0] bits_q;
	word_t       h_q [8];
	word_t       v_q [8];
	word_t       w_q [16];
	logic [5:0]  round_q;
	logic        busy_q;
	logic        fin_q;
	logic [7:0]  push_byte;
	logic        start;
	word_t       t1;
	word_t       t2;
	word_t       w_new;

	always_comb begin
		case (cmd.sel)
			PUSH_DATA: push_byte = data_byte;
			PUSH_PAD:  push_byte = PadByte;
			PUSH_ZERO: push_byte = 8'h00;
			PUSH_LEN:  push_byte = bits_q[8*(7 - 32'(cmd.len_idx)) +: 8];
			default:   push_byte = 8'h00;
		endcase
	end

	assign buf_next = {buf_q[8*BlkBytes-9:0], push_byte};
	assign start    = cmd.push && (pos_q == 6'd63);

	assign t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ RoundK[round_q] + w_q[0];
	assign t2 = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign w_new = w_q[0] + sml_sig0(w_q[1]) + w_q[9] + sml_sig1(w_q[14]);

	// control state and chain hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			bits_q  <= '0;
			busy_q  <= 1'b0;
			fin_q   <= 1'b0;
			round_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= Iv[i];
		end else begin
			if (cmd.push) begin
				pos_q <= pos_q + 6'd1;
				if (cmd.sel == PUSH_DATA) bits_q <= bits_q + 64'd8;
			end
			if (start) begin
				busy_q  <= 1'b1;
				fin_q   <= 1'b0;
				round_q <= '0;
			end else if (busy_q && !fin_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == 6'd63) fin_q <= 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b0;
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end
			if (cmd.clear_msg) begin
				bits_q <= '0;
				for (int i = 0; i < 8; i++) h_q[i] <= Iv[i];
			end
		end
	end

	// payload: buffer, schedule window, working variables
	always_ff @(posedge clk) begin
		if (cmd.push) buf_q <= buf_next;
		if (start) begin
			for (int j = 0; j < 16; j++) w_q[j] <= buf_next[8*BlkBytes-1-32*j -: 32];
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (busy_q && !fin_q) begin
			for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign sts.busy      = busy_q;
	assign sts.pos_last  = (pos_q == 6'd63);
	assign sts.pos_at_56 = (pos_q == 6'd56);
	assign digest_word   = h_q[cmd.out_idx];
endmodule

### src/sbh_ctrl.sv
// Controller: accepts byte requests, sequences padding and length, emits the digest.
// Depends on sbh_pkg.
module sbh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              has_byte,
	input  logic              end_of_message,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        word_index,
	output logic              last_word,
	input  sbh_pkg::sbh_sts_t sts,
	output sbh_pkg::sbh_cmd_t cmd
);
	import sbh_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_PAD, S_ZERO, S_LEN, S_WAIT, S_OUT} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;
	logic       can_push;
	logic       accept;

	assign can_push = !(sts.busy && sts.pos_last);
	assign in_ready = (state_q == S_IDLE) && can_push;
	assign accept   = in_valid && in_ready;
	assign out_valid  = (state_q == S_OUT);
	assign word_index = cnt_q;
	assign last_word  = (cnt_q == 3'd7);

	always_comb begin
		cmd = '{push: 1'b0, sel: PUSH_DATA, len_idx: cnt_q, out_idx: cnt_q, clear_msg: 1'b0};
		case (state_q)
			S_IDLE: cmd.push = accept && has_byte;
			S_PAD: begin
				cmd.sel  = PUSH_PAD;
				cmd.push = can_push;
			end
			S_ZERO: begin
				cmd.sel  = PUSH_ZERO;
				cmd.push = can_push && !sts.pos_at_56;
			end
			S_LEN: begin
				cmd.sel  = PUSH_LEN;
				cmd.push = can_push;
			end
			S_OUT: cmd.clear_msg = out_ready && last_word;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (accept && end_of_message) state_q <= S_PAD;
				S_PAD: if (can_push) state_q <= S_ZERO;
				S_ZERO: if (sts.pos_at_56) begin
					state_q <= S_LEN;
					cnt_q   <= '0;
				end
				S_LEN: if (can_push) begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) state_q <= S_WAIT;
				end
				S_WAIT: if (!sts.busy) begin
					state_q <= S_OUT;
					cnt_q   <= '0;
				end
				S_OUT: if (out_ready) begin
					cnt_q <= cnt_q + 3'd1;
					if (last_word) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### src/sha256_byte_stream_hasher.sv
// SHA-256 hasher over a byte stream: top level joining controller and datapath.
// Depends on sbh_pkg, sbh_in_if, sbh_out_if, sbh_ctrl, sbh_datapath.
//
//   channel  | dir | payload                                   | moves
//   in_ch    | in  | data_byte[7:0], has_byte, end_of_message  | one byte request
//   out_ch   | out | digest_word[31:0], word_index[2:0], last  | one digest word
//
// The request that fills a 64-byte block starts a compression (load, 64 rounds,
// chain add) on the single round unit; bytes keep arriving meanwhile, but the next
// full block waits. Ending a message pushes a pad byte, a zero fill (up to 63
// bytes) and eight length bytes, stalls for any compression still running, then
// runs the final compression and eight output words. Reset clears all control and
// loads the initial hash. out_ch stalls hold the word; no input is taken while
// output runs.
module sha256_byte_stream_hasher (
	input logic      clk,
	input logic      arst_n,
	sbh_in_if.sink   in_ch,
	sbh_out_if.source out_ch
);
	import sbh_pkg::*;

	sbh_cmd_t cmd;
	sbh_sts_t sts;

	// sequence requests, padding and output
	sbh_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_ch.valid),
		.in_ready       (in_ch.ready),
		.has_byte       (in_ch.has_byte),
		.end_of_message (in_ch.end_of_message),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.word_index     (out_ch.word_index),
		.last_word      (out_ch.last_word),
		.sts            (sts),
		.cmd            (cmd)
	);

	// hold the block, run the rounds, keep the chain hash
	sbh_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (in_ch.data_byte),
		.sts         (sts),
		.digest_word (out_ch.digest_word)
	);

`ifndef NO_ASSERTIONS
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken during digest output");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.last_word) |=> !out_ch.valid)
		else $error("output continues after last word");
	a_word_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && !out_ch.last_word) |=>
		(out_ch.valid && out_ch.word_index == $past(out_ch.word_index) + 3'd1))
		else $error("digest word index did not advance");
	a_no_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !sts.busy) else $error("digest shown during compression");
`endif
endmodule

### dv/tb_sha256_byte_stream_hasher.sv
// Self-checking testbench for sha256_byte_stream_hasher: drives byte requests,
// predicts SHA-256 digests and compares each digest word as it leaves the block.
// Depends on sbh_pkg, sbh_in_if, sbh_out_if and the hasher RTL.

// Digest predictor plus a queue of expected digest words.
class digest_board;
	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	logic [31:0]  hash_state [8];
	logic [7:0]   msg_block [64];
	logic [63:0]  bit_count;
	digest_word_t pending_words [$];
	int           errors;

	function new();
		errors = 0;
		restart();
	endfunction

	function void restart();
		for (int i = 0; i < 8; i++) hash_state[i] = sbh_pkg::Iv[i];
		bit_count = '0;
	endfunction

	static function logic [31:0] rotr(logic [31:0] v, int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	function void compress();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int j = 0; j < 16; j++)
			w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
		for (int j = 16; j < 64; j++) begin
			s0 = rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3);
			s1 = rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10);
			w[j] = w[j-16] + s0 + w[j-7] + s1;
		end
		a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
		e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
		for (int t = 0; t < 64; t++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ sbh_pkg::RoundK[t] + w[t];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
		hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
	endfunction

	// Note one accepted request; queue the digest when it ends a message.
	function void note_request(logic [7:0] data, logic has, logic eom);
		int pos;
		digest_word_t dw;
		if (has) begin
			pos = int'(bit_count[8:3]);
			msg_block[pos] = data;
			bit_count += 64'd8;
			if (pos == 63) compress();
		end
		if (!eom) return;
		pos = int'(bit_count[8:3]);
		msg_block[pos] = sbh_pkg::PadByte;
		for (int j = pos + 1; j < 64; j++) msg_block[j] = 8'h00;
		if (pos >= 56) begin
			compress();
			for (int j = 0; j < 64; j++) msg_block[j] = 8'h00;
		end
		for (int j = 0; j < 8; j++) msg_block[63-j] = bit_count[8*j +: 8];
		compress();
		for (int j = 0; j < 8; j++) begin
			dw.word = hash_state[j];
			dw.idx  = 3'(j);
			dw.last = (j == 7);
			pending_words.push_back(dw);
		end
		restart();
	endfunction

	// Compare one accepted digest word against the oldest expectation.
	function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
		digest_word_t dw;
		if (pending_words.size() == 0) begin
			$display("%0t: unexpected digest word %h idx %0d last %0b", $time, word, idx, last);
			errors++;
			return;
		end
		dw = pending_words.pop_front();
		if (word !== dw.word) begin
			$display("%0t: digest_word expected %h actual %h", $time, dw.word, word);
			errors++;
		end
		if (idx !== dw.idx) begin
			$display("%0t: word_index expected %0d actual %0d", $time, dw.idx, idx);
			errors++;
		end
		if (last !== dw.last) begin
			$display("%0t: last_word expected %0b actual %0b", $time, dw.last, last);
			errors++;
		end
	endfunction
endclass

module tb_sha256_byte_stream_hasher;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;

	sbh_in_if  in_ch ();
	sbh_out_if out_ch ();

	sha256_byte_stream_hasher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	digest_board board;
	// When set, both sides run without idle cycles.
	bit          no_idle;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: far above the slowest correct run.
	initial begin
		#20ms;
		$display("sha256_byte_stream_hasher: mismatch");
		$finish;
	end

	// Send one request and hold it until the block takes it; idle first at random.
	task automatic send_request(logic [7:0] data, logic has, logic eom);
		if (!no_idle) begin
			while ($urandom_range(99) < 15) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_ch.valid          <= 1'b1;
		in_ch.data_byte      <= data;
		in_ch.has_byte       <= has;
		in_ch.end_of_message <= eom;
		do @(posedge clk); while (!in_ch.ready);
		board.note_request(data, has, eom);
	endtask

	// Send a whole message of n random bytes, then end it; the end may ride
	// with the last byte or come as a separate empty request.
	task automatic send_message(int n);
		bit joined;
		joined = (n > 0) && $urandom_range(1);
		for (int i = 0; i < n; i++)
			send_request(8'($urandom), 1'b1, joined && (i == n - 1));
		if (!joined) send_request(8'($urandom), 1'b0, 1'b1);
	endtask

	// Receiver: stall at random, check every accepted word.
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				board.check_word(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
			out_ch.ready <= no_idle || ($urandom_range(99) >= 15);
		end
	end

	initial begin
		int sent;
		int n;
		board     = new();
		no_idle   = 1'b0;
		in_ch.valid          <= 1'b0;
		in_ch.data_byte      <= '0;
		in_ch.has_byte       <= 1'b0;
		in_ch.end_of_message <= 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, "abc", extremes, idle requests, padding edges.
		send_request(8'h00, 1'b0, 1'b1);
		send_request(8'h61, 1'b1, 1'b0);
		send_request(8'h62, 1'b1, 1'b0);
		send_request(8'h63, 1'b1, 1'b1);
		send_request(8'hff, 1'b0, 1'b0);
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'hff, 1'b1, 1'b0);
		send_request(8'h5a, 1'b0, 1'b0);
		send_request(8'ha5, 1'b0, 1'b1);
		send_request(8'hff, 1'b1, 1'b1);
		sent = 10;
		// Lengths hitting the extra-block case and exact block boundaries.
		send_message(55); send_message(56); send_message(63); send_message(64);
		sent += 55 + 56 + 63 + 64 + 4;

		// Random: mostly short messages, a few longer, sprinkled with empty requests;
		// one stretch runs with no idling.
		while (sent < 470) begin
			no_idle = (sent > 300 && sent < 400);
			if ($urandom_range(9) == 0) begin
				send_request(8'($urandom), 1'b0, 1'b0);
				sent++;
			end else begin
				n = ($urandom_range(9) == 0) ? $urandom_range(130, 50) : $urandom_range(20);
				send_message(n);
				sent += n + 1;
			end
		end
		in_ch.valid <= 1'b0;
		no_idle = 1'b0;

		while (board.pending_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0) begin
			$display("sha256_byte_stream_hasher: match");
		end else begin
			$display("sha256_byte_stream_hasher: mismatch");
		end
		$finish;
	end
endmodule

### files.f
src/sbh_pkg.sv
src/sbh_in_if.sv
src/sbh_out_if.sv
src/sbh_datapath.sv
src/sbh_ctrl.sv
src/sha256_byte_stream_hasher.sv
dv/tb_sha256_byte_stream_hasher.sv
